@@ design/sfbet_pkg.sv @@
// Shared types and constants for the spectral flux band energy tracker.
package sfbet_pkg;
   localparam int NumBinsDefault = 512;
   localparam logic [24:0] SumLimit = 25'd33553920;
   localparam logic [3:0] CsrLowFirst = 4'd0;
   localparam logic [3:0] CsrLowFinal = 4'd1;
   localparam logic [3:0] CsrMidFirst = 4'd2;
   localparam logic [3:0] CsrMidFinal = 4'd3;
   localparam logic [3:0] CsrHighFirst = 4'd4;
   localparam logic [3:0] CsrHighFinal = 4'd5;
   localparam logic [3:0] CsrAttack = 4'd6;
   localparam logic [3:0] CsrRelease = 4'd7;

   typedef struct packed {
      logic clear_run;
      logic bin_load;
      logic bin_go;
      logic smooth_go;
      logic [3:0] smooth_sel;
      logic kick_mul_go;
      logic kick_lo_go;
      logic kick_go;
      logic sums_clear;
      logic [2:0] emit_sel;
   } cmd_type;

   typedef struct packed {
      logic last_bin;
      logic clear_done;
   } stat_type;
endpackage

@@ design/spectral_flux_band_energy_tracker_top.sv @@
// Top level of the spectral flux band energy tracker.
// A bin's flux word is registered in the bin state; the next bin waits until it is taken.
// A frame-end bin adds serial smoothing of sums and kick on one shared blend unit,
// then four summary words, one per cycle when the output is not stalled.
// Reset is synchronous; afterwards a pass over all NUM_BINS entries clears the previous
// magnitude memory before the first word is accepted.
module spectral_flux_band_energy_tracker_top #(
   parameter int NUM_BINS = sfbet_pkg::NumBinsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,   // magnitude
   input  logic req_tlast,          // frame_end
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // bin_flux, energy_sum, flux_sum, energy_smoothed, flux_smoothed, kick_level, pad
   output logic [167:0] rsp_tdata,
   output logic [2:0] rsp_tuser,    // record_kind, band
   output logic rsp_tlast,          // run_end
   input  logic csr_we,
   input  logic [3:0] csr_index,
   input  logic [15:0] csr_data
);
   import sfbet_pkg::*;
   cmd_type cmd;
   stat_type stat;
   logic [165:0] dp_data;
   logic dp_user;
   logic [1:0] band;

   sfbet_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_band(band), .out_last(rsp_tlast), .stat, .cmd
   );

   sfbet_datapath #(.NUM_BINS(NUM_BINS)) u_dp (
      .clock, .reset, .cmd, .stat, .in_mag(req_tdata), .in_last(req_tlast),
      .csr_we, .csr_index, .csr_data, .out_data(dp_data), .out_user(dp_user)
   );

   assign rsp_tdata = {2'd0, dp_data};
   assign rsp_tuser = {dp_user ? band : 2'd0, dp_user};
endmodule

@@ design/sfbet_datapath.sv @@
// Datapath: previous magnitude memory, band sums, smoothing and the kick envelope.
module sfbet_datapath #(
   parameter int NUM_BINS = sfbet_pkg::NumBinsDefault
) (
   input  logic clock,
   input  logic reset,
   input  sfbet_pkg::cmd_type cmd,
   output sfbet_pkg::stat_type stat,
   input  logic [15:0] in_mag,
   input  logic in_last,
   input  logic csr_we,
   input  logic [3:0] csr_index,
   input  logic [15:0] csr_data,
   output logic [165:0] out_data,
   output logic out_user
);
   import sfbet_pkg::*;
   localparam int PW = $clog2(NUM_BINS);
   localparam int CW = (PW > 9) ? PW : 9;

   logic [15:0] mem [NUM_BINS];
   logic [15:0] prev_ff;
   logic [PW-1:0] pos_ff, pos_in, clr_ff;
   logic clr_done_ff;
   logic [15:0] mag_ff;
   logic last_ff;
   logic [8:0] lf_ff, ll_ff, mf_ff, ml_ff, hf_ff, hl_ff;
   logic [15:0] att_ff, rel_ff;
   logic [24:0] sum_ff [8];
   logic [24:0] sm_ff [8];
   logic [49:0] kick_ff, tgt_ff, kick_in;
   logic [41:0] lo_ff;
   logic [15:0] flux;
   logic [3:0] member;
   logic [15:0] coef, rnd;
   logic [24:0] old_p, new_p;
   logic [41:0] acc;
   logic rise;

   function automatic logic inb(logic [PW-1:0] p, logic [8:0] f, logic [8:0] l);
      logic [CW-1:0] pe;
      pe = CW'(p);
      return (l >= f) && (pe >= CW'(f)) && (pe <= CW'(l));
   endfunction

   function automatic logic [24:0] sadd(logic [24:0] a, logic [15:0] b);
      logic [25:0] s;
      s = {1'b0, a} + 26'(b);
      return (s > 26'(SumLimit)) ? SumLimit : s[24:0];
   endfunction

   assign flux = (mag_ff > prev_ff) ? mag_ff - prev_ff : 16'd0;
   assign member[0] = 1'b1;
   assign member[1] = inb(pos_ff, lf_ff, ll_ff);
   assign member[2] = inb(pos_ff, mf_ff, ml_ff);
   assign member[3] = inb(pos_ff, hf_ff, hl_ff);
   assign stat.last_bin = last_ff;
   assign stat.clear_done = clr_done_ff;
   assign pos_in = (pos_ff == PW'(NUM_BINS - 1)) ? '0 : pos_ff + 1'b1;

   // The kick envelope is blended in two passes of 25 bits each, low half first.
   always_comb begin
      if (cmd.kick_go || cmd.kick_lo_go) begin
         rise = tgt_ff > kick_ff;
         old_p = cmd.kick_go ? kick_ff[49:25] : kick_ff[24:0];
         new_p = cmd.kick_go ? tgt_ff[49:25] : tgt_ff[24:0];
         rnd = cmd.kick_go ? 16'd0 : 16'h8000;
      end else begin
         old_p = sm_ff[cmd.smooth_sel[2:0]];
         new_p = sum_ff[cmd.smooth_sel[2:0]];
         rise = cmd.smooth_sel[3] ? (new_p >= old_p) : (new_p > old_p);
         rnd = 16'h8000;
      end
      coef = rise ? att_ff : rel_ff;
      acc = 42'(old_p) * 42'(coef) + 42'(new_p) * (42'(17'h10000) - 42'(coef))
            + 42'(rnd);
   end

   assign kick_in = {acc[40:0], 9'd0} + 50'(lo_ff[41:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_ff <= 9'd1; ll_ff <= 9'd3; mf_ff <= 9'd3; ml_ff <= 9'd70;
         hf_ff <= 9'd70; hl_ff <= 9'd464; att_ff <= 16'd0; rel_ff <= 16'd55384;
         pos_ff <= '0; clr_ff <= '0; clr_done_ff <= 1'b0; kick_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            sum_ff[i] <= '0;
            sm_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CsrLowFirst: lf_ff <= csr_data[8:0];
               CsrLowFinal: ll_ff <= csr_data[8:0];
               CsrMidFirst: mf_ff <= csr_data[8:0];
               CsrMidFinal: ml_ff <= csr_data[8:0];
               CsrHighFirst: hf_ff <= csr_data[8:0];
               CsrHighFinal: hl_ff <= csr_data[8:0];
               CsrAttack: att_ff <= csr_data;
               CsrRelease: rel_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear_run && !clr_done_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == PW'(NUM_BINS - 1)) clr_done_ff <= 1'b1;
         end
         if (cmd.bin_go) begin
            for (int b = 0; b < 4; b++) begin
               if (member[b]) begin
                  sum_ff[b] <= sadd(sum_ff[b], mag_ff);
                  sum_ff[4+b] <= sadd(sum_ff[4+b], flux);
               end
            end
            pos_ff <= last_ff ? '0 : pos_in;
         end
         if (cmd.smooth_go) sm_ff[cmd.smooth_sel[2:0]] <= acc[40:16];
         if (cmd.kick_go) kick_ff <= kick_in;
         if (cmd.sums_clear) begin
            for (int i = 0; i < 8; i++) sum_ff[i] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_run && !clr_done_ff) mem[clr_ff] <= '0;
      else if (cmd.bin_go) mem[pos_ff] <= mag_ff;
      prev_ff <= mem[pos_ff];
      if (cmd.bin_load) begin
         mag_ff <= in_mag;
         last_ff <= in_last;
      end
      if (cmd.kick_mul_go) tgt_ff <= {25'd0, sm_ff[1]} * {25'd0, sm_ff[5]};
      if (cmd.kick_lo_go) lo_ff <= acc;
      if (cmd.bin_go) begin
         out_data <= {150'd0, flux};
         out_user <= 1'b0;
      end else if (cmd.emit_sel[2]) begin
         out_data <= {kick_ff, sm_ff[{1'b1, cmd.emit_sel[1:0]}],
                      sm_ff[{1'b0, cmd.emit_sel[1:0]}], sum_ff[{1'b1, cmd.emit_sel[1:0]}],
                      sum_ff[{1'b0, cmd.emit_sel[1:0]}], 16'd0};
         out_user <= 1'b1;
      end
   end
endmodule

@@ design/sfbet_ctrl.sv @@
// Controller state machine sequencing bins, smoothing and summary words.
module sfbet_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic out_valid,
   input  logic out_ready,
   output logic [1:0] out_band,
   output logic out_last,
   input  sfbet_pkg::stat_type stat,
   output sfbet_pkg::cmd_type cmd
);
   import sfbet_pkg::*;
   typedef enum logic [2:0] {ClearSt, IdleSt, ReadSt, BinSt, WaitSt, SmoothSt, EmitSt}
      state_type;
   state_type state_ff;
   logic [3:0] step_ff;
   logic valid_ff, last_ff;
   logic [1:0] band_ff;

   assign req_tready = (state_ff == IdleSt) && !valid_ff;
   assign out_valid = valid_ff;
   assign out_band = band_ff;
   assign out_last = last_ff;

   always_comb begin
      cmd = '0;
      cmd.clear_run = (state_ff == ClearSt);
      cmd.bin_load = req_tvalid && req_tready;
      cmd.bin_go = (state_ff == BinSt);
      if (state_ff == SmoothSt) begin
         unique case (step_ff)
            4'd0: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b0000; end
            4'd1: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b0100; end
            4'd2: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b1101; end
            4'd3: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b1001; end
            4'd4: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b1110; end
            4'd5: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b1010; end
            4'd6: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b1111; end
            4'd7: begin cmd.smooth_go = 1'b1; cmd.smooth_sel = 4'b1011; end
            4'd8: cmd.kick_mul_go = 1'b1;
            4'd9: cmd.kick_lo_go = 1'b1;
            4'd10: cmd.kick_go = 1'b1;
            default: ;
         endcase
      end
      if (state_ff == EmitSt && (!valid_ff || out_ready))
         cmd.emit_sel = {1'b1, step_ff[1:0]};
      if (state_ff == EmitSt && (!valid_ff || out_ready) && step_ff[1:0] == 2'd3)
         cmd.sums_clear = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ClearSt;
         step_ff <= '0;
         valid_ff <= 1'b0;
         last_ff <= 1'b0;
         band_ff <= '0;
      end else begin
         if (valid_ff && out_ready && state_ff != EmitSt) valid_ff <= 1'b0;
         unique case (state_ff)
            ClearSt: if (stat.clear_done) state_ff <= IdleSt;
            IdleSt: if (req_tvalid && !valid_ff) state_ff <= ReadSt;
            ReadSt: state_ff <= BinSt;
            BinSt: begin
               valid_ff <= 1'b1;
               band_ff <= 2'd0;
               last_ff <= !stat.last_bin;
               step_ff <= '0;
               state_ff <= stat.last_bin ? SmoothSt : IdleSt;
            end
            SmoothSt: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd10) begin
                  step_ff <= '0;
                  state_ff <= EmitSt;
               end
            end
            EmitSt: if (!valid_ff || out_ready) begin
               valid_ff <= 1'b1;
               band_ff <= step_ff[1:0];
               last_ff <= (step_ff[1:0] == 2'd3);
               step_ff <= step_ff + 1'b1;
               if (step_ff[1:0] == 2'd3) state_ff <= IdleSt;
            end
            default: state_ff <= IdleSt;
         endcase
      end
   end
endmodule

@@ sim/tb.sv @@
// Testbench for the spectral flux band energy tracker: directed and random bins checked
// against a predictor.
`timescale 1ns / 100ps
module tb;
   import sfbet_pkg::*;

   localparam int NBINS = 512;
   localparam logic KIND_BIN = 1'b0;
   localparam logic KIND_SUM = 1'b1;
   localparam logic [1:0] BAND_WHOLE = 2'd0;
   localparam logic [1:0] BAND_LOW = 2'd1;
   localparam logic [1:0] BAND_MID = 2'd2;
   localparam logic [1:0] BAND_HIGH = 2'd3;
   localparam logic [3:0] CSR_UNUSED = 4'd8;
   localparam logic [3:0] CSR_TOP = 4'hF;

   typedef struct packed {
      logic kind;
      logic [1:0] band;
      logic [15:0] bin_flux;
      logic [24:0] energy_sum;
      logic [24:0] flux_sum;
      logic [24:0] energy_smoothed;
      logic [24:0] flux_smoothed;
      logic [49:0] kick_level;
      logic run_end;
   } record_type;

   typedef struct {
      logic [15:0] mag;
      logic last;
      logic typed;
      logic [15:0] flux;
   } bin_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [167:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [3:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   // Predictor state.
   logic [8:0] band_lo [0:2];
   logic [8:0] band_hi [0:2];
   logic [15:0] coef_attack, coef_release;
   logic [15:0] prev_mag [0:NBINS-1];
   int unsigned bin_pos;
   logic [24:0] raw_sums [0:7];
   logic [24:0] smooth_sums [0:7];
   logic [49:0] kick_env;

   record_type record_q[$];
   int errors = 0;
   int bins_sent = 0;
   int frames_sent = 0;
   int words_seen = 0;
   bit calm = 1'b0;
   bit hold_rsp = 1'b0;

   spectral_flux_band_energy_tracker_top u_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [49:0] blend(logic [49:0] old, logic [49:0] x, logic [15:0] c);
      logic [79:0] acc;
      acc = 80'(old) * 80'(c) + 80'(x) * (80'd65536 - 80'(c)) + 80'd32768;
      return acc[65:16];
   endfunction

   function automatic logic [24:0] sat_add(logic [24:0] a, logic [24:0] b);
      logic [25:0] s;
      s = 26'(a) + 26'(b);
      return (s > 26'(SumLimit)) ? SumLimit : s[24:0];
   endfunction

   function automatic void smooth_entry(int idx, bit inclusive);
      logic [24:0] x, s;
      bit rise;
      x = raw_sums[idx];
      s = smooth_sums[idx];
      rise = inclusive ? (x >= s) : (x > s);
      smooth_sums[idx] = 25'(blend(50'(s), 50'(x), rise ? coef_attack : coef_release));
   endfunction

   task automatic predict_reset();
      band_lo[0] = 9'd1; band_hi[0] = 9'd3;
      band_lo[1] = 9'd3; band_hi[1] = 9'd70;
      band_lo[2] = 9'd70; band_hi[2] = 9'd464;
      coef_attack = 16'd0; coef_release = 16'd55384;
      foreach (prev_mag[i]) prev_mag[i] = '0;
      bin_pos = 0;
      foreach (raw_sums[i]) begin
         raw_sums[i] = '0;
         smooth_sums[i] = '0;
      end
      kick_env = '0;
   endtask

   function automatic void predict_csr(logic [3:0] idx, logic [15:0] val);
      case (idx)
         CsrLowFirst: band_lo[0] = val[8:0];
         CsrLowFinal: band_hi[0] = val[8:0];
         CsrMidFirst: band_lo[1] = val[8:0];
         CsrMidFinal: band_hi[1] = val[8:0];
         CsrHighFirst: band_lo[2] = val[8:0];
         CsrHighFinal: band_hi[2] = val[8:0];
         CsrAttack: coef_attack = val;
         CsrRelease: coef_release = val;
         default: ;
      endcase
   endfunction

   function automatic void predict_bin(logic [15:0] mag, logic last, logic typed,
                                       logic [15:0] typed_flux);
      logic [15:0] flux;
      bit member [0:3];
      record_type r;
      logic [49:0] target;
      flux = (mag > prev_mag[bin_pos]) ? mag - prev_mag[bin_pos] : '0;
      member[0] = 1'b1;
      for (int b = 0; b < 3; b++)
         member[b+1] = band_hi[b] >= band_lo[b] && bin_pos >= band_lo[b]
                       && bin_pos <= band_hi[b];
      for (int b = 0; b < 4; b++) begin
         if (member[b]) begin
            raw_sums[b] = sat_add(raw_sums[b], 25'(mag));
            raw_sums[4+b] = sat_add(raw_sums[4+b], 25'(flux));
         end
      end
      prev_mag[bin_pos] = mag;
      bin_pos = (bin_pos + 1) % NBINS;
      r = '0;
      r.kind = KIND_BIN;
      r.bin_flux = typed ? typed_flux : flux;
      r.run_end = !last;
      record_q.push_back(r);
      if (!last) return;
      smooth_entry(0, 1'b0);
      smooth_entry(4, 1'b0);
      for (int b = 1; b < 4; b++) begin
         smooth_entry(4 + b, 1'b1);
         smooth_entry(b, 1'b1);
      end
      target = 50'(smooth_sums[1]) * 50'(smooth_sums[5]);
      kick_env = blend(kick_env, target, (target > kick_env) ? coef_attack : coef_release);
      for (int b = 0; b < 4; b++) begin
         r = '0;
         r.kind = KIND_SUM;
         r.band = 2'(b);
         r.energy_sum = raw_sums[b];
         r.flux_sum = raw_sums[4+b];
         r.energy_smoothed = smooth_sums[b];
         r.flux_smoothed = smooth_sums[4+b];
         r.kick_level = kick_env;
         r.run_end = (2'(b) == BAND_HIGH);
         record_q.push_back(r);
      end
      foreach (raw_sums[i]) raw_sums[i] = '0;
      bin_pos = 0;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      record_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         got.kind = rsp_tuser[0];
         got.band = rsp_tuser[2:1];
         got.bin_flux = rsp_tdata[15:0];
         got.energy_sum = rsp_tdata[40:16];
         got.flux_sum = rsp_tdata[65:41];
         got.energy_smoothed = rsp_tdata[90:66];
         got.flux_smoothed = rsp_tdata[115:91];
         got.kick_level = rsp_tdata[165:116];
         got.run_end = rsp_tlast;
         if (record_q.size() == 0) begin
            $error("unexpected word: kind %0d band %0d", got.kind, got.band);
            errors++;
         end else begin
            want = record_q.pop_front();
            if (got.kind !== want.kind) begin
               $error("record_kind: expected %0d, got %0d", want.kind, got.kind); errors++;
            end
            if (got.band !== want.band) begin
               $error("band: expected %0d, got %0d", want.band, got.band); errors++;
            end
            if (got.bin_flux !== want.bin_flux) begin
               $error("bin_flux: expected %0d, got %0d", want.bin_flux, got.bin_flux);
               errors++;
            end
            if (got.energy_sum !== want.energy_sum) begin
               $error("energy_sum: expected %0d, got %0d", want.energy_sum, got.energy_sum);
               errors++;
            end
            if (got.flux_sum !== want.flux_sum) begin
               $error("flux_sum: expected %0d, got %0d", want.flux_sum, got.flux_sum);
               errors++;
            end
            if (got.energy_smoothed !== want.energy_smoothed) begin
               $error("energy_smoothed: expected %0d, got %0d",
                      want.energy_smoothed, got.energy_smoothed);
               errors++;
            end
            if (got.flux_smoothed !== want.flux_smoothed) begin
               $error("flux_smoothed: expected %0d, got %0d",
                      want.flux_smoothed, got.flux_smoothed);
               errors++;
            end
            if (got.kick_level !== want.kick_level) begin
               $error("kick_level: expected %0d, got %0d", want.kick_level, got.kick_level);
               errors++;
            end
            if (got.run_end !== want.run_end) begin
               $error("run_end: expected %0d, got %0d", want.run_end, got.run_end); errors++;
            end
         end
      end
   end

   // Output backpressure.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_bin(logic [15:0] mag, logic last, logic typed = 1'b0,
                           logic [15:0] flux = '0);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= mag;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_bin(mag, last, typed, flux);
      bins_sent++;
      if (last) frames_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (record_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [3:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      predict_csr(idx, val);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(logic [8:0] lf, logic [8:0] ll, logic [8:0] mf, logic [8:0] ml,
                            logic [8:0] hf, logic [8:0] hl, logic [15:0] at,
                            logic [15:0] rl);
      wait_idle();
      write_csr(CsrLowFirst, 16'(lf));
      write_csr(CsrLowFinal, 16'(ll));
      write_csr(CsrMidFirst, 16'(mf));
      write_csr(CsrMidFinal, 16'(ml));
      write_csr(CsrHighFirst, 16'(hf));
      write_csr(CsrHighFinal, 16'(hl));
      write_csr(CsrAttack, at);
      write_csr(CsrRelease, rl);
   endtask

   task automatic random_frame(int len, bit loud);
      logic [15:0] m;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 3))
            0: m = loud ? 16'hFFFF : 16'($urandom_range(0, 255));
            1: m = 16'($urandom);
            2: m = '0;
            default: m = 16'($urandom_range(16'h8000, 16'hFFFF));
         endcase
         send_bin(m, i == len - 1);
      end
   endtask

   bin_row_type rows [] = '{
      '{16'h0000, 1'b0, 1'b1, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
      '{16'h8000, 1'b0, 1'b1, 16'h8000},
      '{16'h0001, 1'b0, 1'b1, 16'h0001},
      '{16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
      '{16'h5555, 1'b1, 1'b1, 16'h5555},
      '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
      '{16'h0000, 1'b0, 1'b1, 16'h0000},
      '{16'h0000, 1'b0, 1'b1, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b1, 16'hFFFE},
      '{16'hAAAA, 1'b0, 1'b1, 16'h2AAB},
      '{16'h5555, 1'b1, 1'b1, 16'h0000},
      '{16'h1234, 1'b1, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b1, 1'b1, 16'hEDCB},
      '{16'h0000, 1'b1, 1'b1, 16'h0000}
   };

   initial begin
      #50ms;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      int limit;
      predict_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_bin(rows[i].mag, rows[i].last, rows[i].typed, rows[i].flux);

      // Full-width bands, extreme weights; unknown index must be ignored.
      write_all(9'd0, 9'd511, 9'd0, 9'd511, 9'd0, 9'd511, 16'hFFFF, 16'h0000);
      write_csr(CSR_UNUSED, 16'hFFFF);
      write_csr(CSR_TOP, 16'h0000);
      for (int f = 0; f < 8; f++) random_frame($urandom_range(1, 12), f[0]);
      hold_rsp = 1'b1;
      random_frame(60, 1'b1);

      // Empty bands and the opposite weights.
      write_all(9'd5, 9'd4, 9'd511, 9'd0, 9'd2, 9'd1, 16'h0000, 16'hFFFF);
      for (int f = 0; f < 6; f++) random_frame($urandom_range(1, 10), f[0]);

      for (int p = 0; p < 4; p++) begin
         write_all(9'($urandom_range(0, 6)), 9'($urandom_range(0, 12)),
                   9'($urandom_range(0, 12)), 9'($urandom_range(4, 40)),
                   9'($urandom_range(8, 40)), 9'($urandom_range(0, 511)),
                   16'($urandom), 16'($urandom));
         if (p == 3) calm = 1'b1;
         for (int f = 0; f < 2; f++)
            random_frame(($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                         : $urandom_range(1, 8), $urandom_range(0, 1));
      end

      req_tvalid <= 1'b0;
      limit = 0;
      while (record_q.size() != 0 && limit < 100000) begin
         @(posedge clock);
         limit++;
      end
      repeat (40) @(posedge clock);
      $display("tb: %0d bins in %0d frames sent, %0d words checked, %0d mismatches",
               bins_sent, frames_sent, words_seen, errors);
      $display("tb: covered band extremes, empty bands, random bands and a long output stall");
      if (errors == 0 && record_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         if (record_q.size() != 0) $error("%0d expected words never arrived", record_q.size());
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
